// ===== hw/rtl/mbe_pkg.sv =====
// Package for the escape-time block: fixed-point format, derived widths and result type.
// Used by mbe_core and mandelbrot_escape_time. No dependencies.
package mbe_pkg;

  // Fixed-point format of c and z.
  localparam int FRAC_BITS = 28;
  localparam int PT_W      = 32;
  localparam int CNT_W     = 16;

  // While z has not escaped, |re| and |im| stay at or below 2.0.
  localparam int MAG_W  = FRAC_BITS + 2;
  localparam int PROD_W = 2 * MAG_W;
  // A truncated square is at most 4.0.
  localparam int SQ_W   = FRAC_BITS + 3;
  // The cross term 2*re*im is at most 8.0 in magnitude.
  localparam int CM_W   = FRAC_BITS + 4;
  // Signed working width for re' and im'.
  localparam int WIDE_W = ((CM_W > PT_W) ? CM_W : PT_W) + 2;

  localparam logic [CNT_W-1:0] LIMIT_RESET = CNT_W'(256);

  // One result word.
  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic             escaped;
  } mbe_res_t;

endpackage

// ===== hw/rtl/mbe_core.sv =====
// Iteration engine: one shared multiplier stepped by a small sequencer.
// Depends on mbe_pkg.
module mbe_core import mbe_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic signed [PT_W-1:0]  c_real_i,
  input  logic signed [PT_W-1:0]  c_imag_i,
  input  logic [CNT_W-1:0]        limit_i,
  output logic                    busy_o,
  output logic                    res_valid_o,
  input  logic                    res_take_i,
  output mbe_res_t                res_o
);

  localparam logic [WIDE_W-1:0] TWO_RAW  = WIDE_W'(1) << (FRAC_BITS + 1);
  localparam logic [SQ_W:0]     FOUR_RAW = (SQ_W + 1)'(1) << (FRAC_BITS + 2);

  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_ADD    = 7'b0000010,
    ST_CHK    = 7'b0000100,
    ST_SQ_RE  = 7'b0001000,
    ST_SQ_IM  = 7'b0010000,
    ST_CROSS  = 7'b0100000,
    ST_FINISH = 7'b1000000
  } mbe_state_e;

  mbe_state_e                state_q, state_d;
  logic signed [WIDE_W-1:0]  cr_q, ci_q;
  logic signed [WIDE_W-1:0]  nr_q, ni_q;
  logic signed [WIDE_W-1:0]  cross_q;
  logic [SQ_W-1:0]           sr_q, si_q;
  logic [MAG_W-1:0]          mag_re_q, mag_im_q;
  logic                      sgn_q;
  logic [CNT_W-1:0]          count_q;
  logic                      esc_q;

  logic [WIDE_W-1:0]         mag_nr, mag_ni;
  logic                      out_of_range;
  logic [MAG_W-1:0]          mul_a, mul_b;
  logic [PROD_W-1:0]         prod;
  logic [CM_W-1:0]           cm;
  logic [SQ_W:0]             sq_sum;

  // Magnitudes of the new z and the coarse escape test |re| > 2 or |im| > 2.
  assign mag_nr       = nr_q[WIDE_W-1] ? WIDE_W'(-nr_q) : WIDE_W'(nr_q);
  assign mag_ni       = ni_q[WIDE_W-1] ? WIDE_W'(-ni_q) : WIDE_W'(ni_q);
  assign out_of_range = (mag_nr > TWO_RAW) || (mag_ni > TWO_RAW);

  // Shared multiplier: re*re, then im*im, then re*im for the next iteration.
  always_comb begin
    case (state_q)
      ST_SQ_RE: begin
        mul_a = mag_re_q;
        mul_b = mag_re_q;
      end
      ST_SQ_IM: begin
        mul_a = mag_im_q;
        mul_b = mag_im_q;
      end
      default: begin
        mul_a = mag_re_q;
        mul_b = mag_im_q;
      end
    endcase
  end
  assign prod   = PROD_W'(mul_a) * PROD_W'(mul_b);
  assign cm     = prod[FRAC_BITS-1 +: CM_W];
  assign sq_sum = (SQ_W + 1)'(sr_q) + (SQ_W + 1)'(si_q);

  // Sequencer next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          state_d = (limit_i == '0) ? ST_FINISH : ST_ADD;
        end
      end
      ST_ADD:   state_d = ST_CHK;
      ST_CHK:   state_d = out_of_range ? ST_FINISH : ST_SQ_RE;
      ST_SQ_RE: state_d = ST_SQ_IM;
      ST_SQ_IM: state_d = ST_CROSS;
      ST_CROSS: begin
        if (sq_sum > FOUR_RAW || (count_q + CNT_W'(1)) == limit_i) begin
          state_d = ST_FINISH;
        end else begin
          state_d = ST_ADD;
        end
      end
      ST_FINISH: begin
        if (res_take_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Count and escape flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      esc_q   <= 1'b0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (start_i) begin
            count_q <= '0;
            esc_q   <= 1'b0;
          end
        end
        ST_CHK: begin
          if (out_of_range) begin
            esc_q <= 1'b1;
          end
        end
        ST_CROSS: begin
          if (sq_sum > FOUR_RAW) begin
            esc_q <= 1'b1;
          end else begin
            count_q <= count_q + CNT_W'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          cr_q    <= WIDE_W'(c_real_i);
          ci_q    <= WIDE_W'(c_imag_i);
          sr_q    <= '0;
          si_q    <= '0;
          cross_q <= '0;
        end
      end
      ST_ADD: begin
        nr_q <= WIDE_W'(sr_q) - WIDE_W'(si_q) + cr_q;
        ni_q <= cross_q + ci_q;
      end
      ST_CHK: begin
        mag_re_q <= mag_nr[MAG_W-1:0];
        mag_im_q <= mag_ni[MAG_W-1:0];
        sgn_q    <= nr_q[WIDE_W-1] ^ ni_q[WIDE_W-1];
      end
      ST_SQ_RE: sr_q <= prod[FRAC_BITS +: SQ_W];
      ST_SQ_IM: si_q <= prod[FRAC_BITS +: SQ_W];
      ST_CROSS: begin
        // 2*re*im truncated toward zero, ready for the next iteration.
        cross_q <= sgn_q ? -WIDE_W'(cm) : WIDE_W'(cm);
      end
      default: begin
      end
    endcase
  end

  assign busy_o        = (state_q != ST_IDLE);
  assign res_valid_o   = (state_q == ST_FINISH);
  assign res_o.count   = count_q;
  assign res_o.escaped = esc_q;

endmodule

// ===== hw/rtl/mandelbrot_escape_time.sv =====
// Top level of the escape-time block: limit register, input handshake, output register.
// Depends on mbe_pkg and mbe_core.
//
//  channel  | direction | handshake               | word
//  ---------+-----------+-------------------------+--------------------------------
//  in       | input     | in_valid_i / in_stall_o | point_real_i, point_imag_i
//  out      | output    | out_valid_o/out_stall_i | iteration_count_o, escaped_o
//  cfg      | input     | cfg_we_i                | cfg_wdata_i (iteration limit)
//
// One iteration steps the single shared multiplier sequencer through its ADD,
// CHK, SQ_RE, SQ_IM and CROSS states; a point runs at most limit iterations.
// One point is in work at a time; in_stall_o is high from acceptance until the
// result moves to the output register, which may still hold the previous word.
// Reset sets the limit to 256 and empties the engine and output register.
// A stalled output word holds; the engine then waits with its finished result.
module mandelbrot_escape_time import mbe_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CNT_W-1:0]       cfg_wdata_i,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic signed [PT_W-1:0] point_real_i,
  input  logic signed [PT_W-1:0] point_imag_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [CNT_W-1:0]       iteration_count_o,
  output logic                   escaped_o
);

  logic [CNT_W-1:0] limit_q;
  logic             busy;
  logic             res_valid;
  logic             res_take;
  mbe_res_t         res;
  mbe_res_t         out_q;
  logic             out_valid_q;

  // Iteration limit register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LIMIT_RESET;
    end else if (cfg_we_i) begin
      limit_q <= cfg_wdata_i;
    end
  end

  // Iteration engine.
  mbe_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (in_valid_i),
    .c_real_i    (point_real_i),
    .c_imag_i    (point_imag_i),
    .limit_i     (limit_q),
    .busy_o      (busy),
    .res_valid_o (res_valid),
    .res_take_i  (res_take),
    .res_o       (res)
  );

  assign in_stall_o = busy;

  // Output register: loads when empty or when its word is taken.
  assign res_take = res_valid && (!out_valid_q || !out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_take) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_take) begin
      out_q <= res;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign iteration_count_o = out_q.count;
  assign escaped_o         = out_q.escaped;

endmodule

// ===== hw/rtl/mbe_checker.sv =====
// Port-level checks for the escape-time block, bound to its top level.
// Depends on mandelbrot_escape_time; no package.
module mbe_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [15:0] iteration_count_o,
  input logic        escaped_o
);

  // A stalled output word stays valid.
  a_out_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output word dropped while stalled");

  // A stalled output word keeps its value.
  a_out_hold_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(iteration_count_o) && $stable(escaped_o))
    else $error("output word changed while stalled");

  // An accepted point raises the input stall after its acceptance.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input not stalled after acceptance");

  // An escaped point never completed the largest possible limit.
  a_escape_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && escaped_o |-> iteration_count_o != 16'hFFFF)
    else $error("escape reported with full count");

endmodule

bind mandelbrot_escape_time mbe_checker u_mbe_checker (.*);

// ===== tb/mandelbrot_escape_time_tb.sv =====
// Self-checking testbench for mandelbrot_escape_time: directed points, then random points.
// Each accepted point is checked word by word against its typed result or a fixed-point escape-time predictor.
// Depends on mbe_pkg and the mandelbrot_escape_time RTL.
`timescale 1ns / 1ps

module mandelbrot_escape_time_tb;
  import mbe_pkg::*;

  // Q4.28 constants used by the stimulus.
  localparam logic signed [PT_W-1:0] RAW_MAX   = 32'sh7FFF_FFFF;
  localparam logic signed [PT_W-1:0] RAW_MIN   = 32'sh8000_0000;
  localparam logic signed [PT_W-1:0] ONE_Q     = 32'sh1000_0000;
  localparam logic signed [PT_W-1:0] TWO_Q     = 32'sh2000_0000;
  localparam logic signed [PT_W-1:0] ONE_HALF  = 32'sh1800_0000;
  localparam logic signed [PT_W-1:0] HALF_Q    = 32'sh0800_0000;
  localparam logic signed [PT_W-1:0] QUARTER_Q = 32'sh0400_0000;
  localparam logic signed [PT_W-1:0] NECK_RE   = -32'sd201326592; // -0.75
  localparam logic signed [PT_W-1:0] TENTH_Q   = 32'sd26843546;
  localparam logic signed [PT_W-1:0] HUNDREDTH = 32'sd2684355;
  localparam logic signed [PT_W-1:0] POINT3_Q  = 32'sd80530637;

  // Escape thresholds of the predictor, raw with FRAC_BITS fraction bits.
  localparam logic [63:0] TWO_RAW  = 64'd2 << FRAC_BITS;
  localparam logic [63:0] FOUR_RAW = 64'd4 << FRAC_BITS;

  // The limit leaves ample margin over the slowest correct run: the points
  // at the largest limit plus every random point at its phase limit with full
  // gaps and stalls.
  localparam int unsigned CYCLE_LIMIT  = 4_000_000;
  localparam int          DRAIN_CYCLES = 8;
  localparam int          PHASES       = 10;
  localparam int          PHASE_POINTS = 58;

  // One directed point: the limit it runs under, c, and a typed result where obvious.
  typedef struct packed {
    logic [CNT_W-1:0]        limit;
    logic signed [PT_W-1:0]  re;
    logic signed [PT_W-1:0]  im;
    logic                    typed;
    mbe_res_t                res;
  } point_row_t;

  localparam int DIR_N = 23;
  localparam point_row_t DIR_ROWS [DIR_N] = '{
    // Reset limit: origin, field extremes, the escape-radius edge, points in and near the set.
    '{16'd256,   32'sd0,     32'sd0,       1'b1, '{16'd256, 1'b0}},
    '{16'd256,   RAW_MAX,    32'sd0,       1'b1, '{16'd0, 1'b1}},
    '{16'd256,   RAW_MIN,    RAW_MIN,      1'b1, '{16'd0, 1'b1}},
    '{16'd256,   32'sd0,     RAW_MAX,      1'b1, '{16'd0, 1'b1}},
    '{16'd256,   RAW_MAX,    RAW_MIN,      1'b1, '{16'd0, 1'b1}},
    '{16'd256,   TWO_Q + 1,  32'sd0,       1'b1, '{16'd0, 1'b1}},
    '{16'd256,   TWO_Q,      32'sd0,       1'b0, '{16'd0, 1'b0}},
    '{16'd256,   -TWO_Q,     32'sd0,       1'b0, '{16'd0, 1'b0}},
    '{16'd256,   32'sd0,     TWO_Q,        1'b0, '{16'd0, 1'b0}},
    '{16'd256,   -ONE_Q,     32'sd0,       1'b0, '{16'd0, 1'b0}},
    '{16'd256,   QUARTER_Q,  32'sd0,       1'b0, '{16'd0, 1'b0}},
    '{16'd256,   32'sd1,     -32'sd1,      1'b0, '{16'd0, 1'b0}},
    '{16'd256,   NECK_RE,    TENTH_Q,      1'b0, '{16'd0, 1'b0}},
    // Zero limit runs no iteration at all.
    '{16'd0,     32'sd0,     32'sd0,       1'b1, '{16'd0, 1'b0}},
    '{16'd0,     RAW_MAX,    RAW_MAX,      1'b1, '{16'd0, 1'b0}},
    // Limit of one, including the magnitude-squared escape path.
    '{16'd1,     32'sd0,     32'sd0,       1'b1, '{16'd1, 1'b0}},
    '{16'd1,     TWO_Q,      32'sd0,       1'b0, '{16'd0, 1'b0}},
    '{16'd1,     ONE_HALF,   ONE_HALF,     1'b0, '{16'd0, 1'b0}},
    // Real-axis edge points: +2 escapes on the last allowed iteration, -2 runs to the limit.
    '{16'd2,     TWO_Q,      32'sd0,       1'b0, '{16'd0, 1'b0}},
    '{16'd2,     -TWO_Q,     32'sd0,       1'b0, '{16'd0, 1'b0}},
    // Largest limit: one point that never escapes, two that escape late.
    '{16'd65535, 32'sd0,     32'sd0,       1'b1, '{16'd65535, 1'b0}},
    '{16'd65535, NECK_RE,    HUNDREDTH,    1'b0, '{16'd0, 1'b0}},
    '{16'd65535, POINT3_Q,   HALF_Q,       1'b0, '{16'd0, 1'b0}}
  };

  // Limits of the first random phases; the later ones are drawn.
  localparam logic [CNT_W-1:0] PHASE_LIMITS [6] = '{16'd3, 16'd16, 16'd1, 16'd50, 16'd100,
                                                    16'd200};

  logic                   clk_i;
  logic                   rst_ni;
  logic                   cfg_we_i;
  logic [CNT_W-1:0]       cfg_wdata_i;
  logic                   in_valid_i;
  logic                   in_stall_o;
  logic signed [PT_W-1:0] point_real_i;
  logic signed [PT_W-1:0] point_imag_i;
  logic                   out_valid_o;
  logic                   out_stall_i;
  logic [CNT_W-1:0]       iteration_count_o;
  logic                   escaped_o;

  mbe_res_t         pending_results [$];
  logic [CNT_W-1:0] iter_limit;
  int               err_cnt;
  int               stall_left;
  int unsigned      cycle_cnt;
  bit               tx_no_gaps;
  bit               rx_no_stall;

  mandelbrot_escape_time u_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .point_real_i      (point_real_i),
    .point_imag_i      (point_imag_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .iteration_count_o (iteration_count_o),
    .escaped_o         (escaped_o)
  );

  // Clock generation.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Magnitude of a signed 64-bit value, wrapping like two's complement.
  function automatic logic [63:0] magn(input logic signed [63:0] v);
    return v[63] ? 64'(-v) : 64'(v);
  endfunction

  // Low 64 bits of the exact 128-bit product shifted right by s.
  function automatic logic [63:0] shr_mul(input logic [63:0] a, input logic [63:0] b,
                                          input int s);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return 64'(p >> s);
  endfunction

  // Escape-time count of c under the given limit, in the block's fixed-point format.
  function automatic mbe_res_t escape_time(input logic signed [PT_W-1:0] c_re,
                                           input logic signed [PT_W-1:0] c_im,
                                           input logic [CNT_W-1:0] limit);
    logic signed [63:0] cr, ci, zr, zi, nr, ni, xterm;
    logic [63:0]        sr, si, mr, mi, cm;
    int unsigned        n;
    mbe_res_t           r;
    cr = c_re;
    ci = c_im;
    zr = '0;
    zi = '0;
    sr = '0;
    si = '0;
    n  = 0;
    r.escaped = 1'b0;
    while (n < limit && !r.escaped) begin
      // 2*re*im, truncated toward zero.
      cm    = shr_mul(magn(zr), magn(zi), FRAC_BITS - 1);
      xterm = ((zr < 0) != (zi < 0)) ? -$signed(cm) : $signed(cm);
      nr    = $signed(sr) - $signed(si) + cr;
      ni    = xterm + ci;
      mr    = magn(nr);
      mi    = magn(ni);
      if (mr > TWO_RAW || mi > TWO_RAW) begin
        r.escaped = 1'b1;
      end else begin
        // The squares are kept for the next iteration.
        sr = shr_mul(mr, mr, FRAC_BITS);
        si = shr_mul(mi, mi, FRAC_BITS);
        if (sr + si > FOUR_RAW) begin
          r.escaped = 1'b1;
        end else begin
          zr = nr;
          zi = ni;
          n++;
        end
      end
    end
    r.count = n[CNT_W-1:0];
    return r;
  endfunction

  // Lower valid and wait until every expected word has been taken.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Write the limit register while the block is idle.
  task automatic write_limit(input logic [CNT_W-1:0] value);
    drain_results();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    iter_limit = value;
    @(posedge clk_i);
  endtask

  // Offer one point after a random gap and record its expected word on acceptance.
  task automatic send_point(input logic signed [PT_W-1:0] re, input logic signed [PT_W-1:0] im,
                            input logic typed, input mbe_res_t typed_res);
    int gap;
    if ($urandom_range(11, 0) == 0) tx_no_gaps = !tx_no_gaps;
    gap = tx_no_gaps ? 0 : $urandom_range(16, 0);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    point_real_i <= re;
    point_imag_i <= im;
    do @(posedge clk_i); while (in_stall_o);
    pending_results.push_back(typed ? typed_res : escape_time(re, im, iter_limit));
  endtask

  // Output side: check each accepted word and draw the stall before the next one.
  always @(posedge clk_i or negedge rst_ni) begin : result_side
    int       n;
    mbe_res_t want;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_left  <= 0;
    end else if (out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected word: count %0d escaped %0b", $time, iteration_count_o,
                 escaped_o);
        err_cnt++;
      end else begin
        want = pending_results.pop_front();
        if (iteration_count_o !== want.count) begin
          $display("%0t: iteration_count expected %0d, got %0d", $time, want.count,
                   iteration_count_o);
          err_cnt++;
        end
        if (escaped_o !== want.escaped) begin
          $display("%0t: escaped expected %0b, got %0b", $time, want.escaped, escaped_o);
          err_cnt++;
        end
      end
      if ($urandom_range(11, 0) == 0) rx_no_stall = !rx_no_stall;
      n = rx_no_stall ? 0 : $urandom_range(16, 0);
      stall_left  <= n;
      out_stall_i <= (n != 0);
    end else if (stall_left > 1) begin
      stall_left <= stall_left - 1;
    end else begin
      stall_left  <= 0;
      out_stall_i <= 1'b0;
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Stimulus: reset, directed table, random phases under changing limits.
  initial begin : stimulus
    logic signed [PT_W-1:0] re, im;
    int                     k;
    err_cnt      = 0;
    cycle_cnt    = 0;
    tx_no_gaps   = 1'b0;
    rx_no_stall  = 1'b0;
    iter_limit   = LIMIT_RESET;
    rst_ni       <= 1'b0;
    cfg_we_i     <= 1'b0;
    cfg_wdata_i  <= '0;
    in_valid_i   <= 1'b0;
    point_real_i <= '0;
    point_imag_i <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < DIR_N; i++) begin
      if (DIR_ROWS[i].limit != iter_limit) write_limit(DIR_ROWS[i].limit);
      send_point(DIR_ROWS[i].re, DIR_ROWS[i].im, DIR_ROWS[i].typed, DIR_ROWS[i].res);
    end

    for (int p = 0; p < PHASES; p++) begin
      write_limit(p < 6 ? PHASE_LIMITS[p] : CNT_W'($urandom_range(160, 2)));
      for (int i = 0; i < PHASE_POINTS; i++) begin
        k = $urandom_range(99, 0);
        if (k < 70) begin
          // Around the set, where runs are long and escapes come late.
          re = $signed($urandom_range(32'd805306367, 0)) - 32'sd590558003;
          im = $signed($urandom_range(32'd697932185, 0)) - 32'sd348966092;
        end else if (k < 85) begin
          re = $urandom;
          im = $urandom;
        end else begin
          // Close to the escape-radius edge on the real axis or on both.
          re = ($urandom_range(1, 0) ? TWO_Q : -TWO_Q) + $signed($urandom_range(8, 0)) - 4;
          if ($urandom_range(1, 0))
            im = ($urandom_range(1, 0) ? TWO_Q : -TWO_Q) + $signed($urandom_range(8, 0)) - 4;
          else
            im = $signed($urandom_range(65535, 0)) - 32768;
        end
        send_point(re, im, 1'b0, '0);
      end
    end

    drain_results();
    if (err_cnt == 0 && pending_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
